@@ hdl/wlpc_pkg.sv @@
`default_nettype none

package wlpc_pkg;

    localparam int WINDOW = 30;

    localparam int LAG_W   = 8;
    localparam int WAIT_W  = 16;
    localparam int SPEED_W = 11;
    localparam int TIME_W  = 8;
    localparam int DIFF_W  = SPEED_W + 1;
    localparam int ENTRY_W = LAG_W + 1 + WAIT_W;

    localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W     = $clog2(WINDOW + 1);
    localparam int LAG_SUM_W  = $clog2(255 * WINDOW + 1);
    localparam int SKIP_SUM_W = FILL_W;
    localparam int WAIT_SUM_W = $clog2(32768 * WINDOW) + 1;
    localparam int L10_W      = LAG_SUM_W + 4;
    localparam int SKIP5_W    = SKIP_SUM_W + 3;
    localparam int D_W        = $clog2(88 * WINDOW + 1);
    localparam int NUM_W      = $clog2(2047 * 88 * WINDOW + 1);
    localparam int PROD_W     = NUM_W + 2;
    localparam int DIVD_W     = NUM_W + 2;
    localparam int CNT_W      = $clog2(SPEED_W);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_LIGHT = 1'b0;
    localparam logic REG_HEAVY = 1'b1;

    localparam logic [SPEED_W-1:0] LIGHT_RESET = SPEED_W'(900);
    localparam logic [SPEED_W-1:0] HEAVY_RESET = SPEED_W'(500);
    localparam logic [SPEED_W-1:0] SPEED_SKIP  = SPEED_W'(1100);
    localparam logic [SPEED_W-1:0] SPEED_NORM  = SPEED_W'(1000);
    localparam logic [TIME_W-1:0]  TIME_SKIP   = TIME_W'(110);
    localparam logic [TIME_W-1:0]  TIME_NORM   = TIME_W'(100);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_PREP = 7'b0000100,
        S_PROD = 7'b0001000,
        S_SUM  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

@@ hdl/windowed_lag_pacing_controller_unit.sv @@
// Channel | Handshake            | Payload
// input   | in_valid / in_stall  | lag_count, skipped, wait_amount
// output  | out_valid / out_stall| quantum_time_ms, speed_milli
// config  | APB write/read       | light_lag_speed (0x0), heavy_lag_speed (0x4)
//
// One beat in gives one beat out; the divide is skipped when the mean lag is low or the wait
// sum is positive.
// Otherwise the shared restoring divider runs: 11 steps for speed, 8 for time.
// One history read and one write-back per beat on the single-port ring memory.
// Reset clears sums and counts; ring entries are only used after being written.
// A new beat is taken while the previous result still waits on out_stall.
`default_nettype none

module windowed_lag_pacing_controller_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [wlpc_pkg::LAG_W-1:0]           lag_count,
    input  wire logic                                 skipped,
    input  wire logic signed [wlpc_pkg::WAIT_W-1:0]   wait_amount,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [wlpc_pkg::TIME_W-1:0]               quantum_time_ms,
    output logic [wlpc_pkg::SPEED_W-1:0]              speed_milli,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [wlpc_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [wlpc_pkg::PDATA_W-1:0]         pwdata,
    output logic [wlpc_pkg::PDATA_W-1:0]              prdata,
    output logic                                      pready
);

    localparam int LAG_W      = wlpc_pkg::LAG_W;
    localparam int WAIT_W     = wlpc_pkg::WAIT_W;
    localparam int SPEED_W    = wlpc_pkg::SPEED_W;
    localparam int TIME_W     = wlpc_pkg::TIME_W;
    localparam int DIFF_W     = wlpc_pkg::DIFF_W;
    localparam int ENTRY_W    = wlpc_pkg::ENTRY_W;
    localparam int SLOT_W     = wlpc_pkg::SLOT_W;
    localparam int FILL_W     = wlpc_pkg::FILL_W;
    localparam int LAG_SUM_W  = wlpc_pkg::LAG_SUM_W;
    localparam int SKIP_SUM_W = wlpc_pkg::SKIP_SUM_W;
    localparam int WAIT_SUM_W = wlpc_pkg::WAIT_SUM_W;
    localparam int L10_W      = wlpc_pkg::L10_W;
    localparam int SKIP5_W    = wlpc_pkg::SKIP5_W;
    localparam int D_W        = wlpc_pkg::D_W;
    localparam int NUM_W      = wlpc_pkg::NUM_W;
    localparam int PROD_W     = wlpc_pkg::PROD_W;
    localparam int DIVD_W     = wlpc_pkg::DIVD_W;
    localparam int CNT_W      = wlpc_pkg::CNT_W;
    localparam int PDATA_W    = wlpc_pkg::PDATA_W;
    localparam int PADDR_W    = wlpc_pkg::PADDR_W;
    localparam int WINDOW     = wlpc_pkg::WINDOW;

    wlpc_pkg::state_t state_reg, state_next;

    logic [LAG_W-1:0]             lag_in_reg, lag_in_next;
    logic                         skip_in_reg, skip_in_next;
    logic signed [WAIT_W-1:0]     wait_in_reg, wait_in_next;

    logic [FILL_W-1:0]            fill_reg, fill_next;
    logic [SLOT_W-1:0]            slot_reg, slot_next;
    logic [LAG_SUM_W-1:0]         lag_sum_reg, lag_sum_next;
    logic [SKIP_SUM_W-1:0]        skip_sum_reg, skip_sum_next;
    logic signed [WAIT_SUM_W-1:0] wait_sum_reg, wait_sum_next;

    logic [SPEED_W-1:0]           light_reg, light_next;
    logic [SPEED_W-1:0]           heavy_reg, heavy_next;

    logic [D_W-1:0]               d_reg, d_next;
    logic [D_W-1:0]               k_reg, k_next;
    logic [NUM_W-1:0]             prod_a_reg, prod_a_next;
    logic signed [PROD_W-1:0]     prod_b_reg, prod_b_next;
    logic [NUM_W-1:0]             num_reg, num_next;
    logic [DIVD_W-1:0]            rem_reg, rem_next;
    logic [DIVD_W-1:0]            den_reg, den_next;
    logic [SPEED_W-1:0]           quo_reg, quo_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         phase_reg, phase_next;
    logic [SPEED_W-1:0]           speed_reg, speed_next;
    logic [TIME_W-1:0]            time_reg, time_next;

    logic                         out_valid_reg, out_valid_next;
    logic [TIME_W-1:0]            out_time_reg, out_time_next;
    logic [SPEED_W-1:0]           out_speed_reg, out_speed_next;

    logic [ENTRY_W-1:0]           ring_mem [WINDOW];
    logic [ENTRY_W-1:0]           rd_data_reg;
    logic                         mem_we;
    logic                         mem_re;

    logic                         in_accept;
    logic                         cfg_write;
    logic                         full;
    logic [LAG_W-1:0]             old_lag;
    logic                         old_skip;
    logic signed [WAIT_W-1:0]     old_wait;

    logic [L10_W-1:0]             l10;
    logic [L10_W-1:0]             n12;
    logic [L10_W-1:0]             n100;
    logic [L10_W-1:0]             t_val;
    logic [SKIP5_W-1:0]           skip5;
    logic                         low_lag;
    logic                         heavy_case;
    logic                         pos_wait;
    logic                         many_skips;

    logic signed [DIFF_W-1:0]     diff;
    logic signed [PROD_W-1:0]     diff_ext;
    logic signed [PROD_W-1:0]     k_ext;
    logic signed [PROD_W-1:0]     num_sum;

    logic [DIVD_W-1:0]            rem_sub;
    logic                         rem_ge;
    logic [SPEED_W-1:0]           quo_shift;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != wlpc_pkg::S_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    assign out_valid       = out_valid_reg;
    assign quantum_time_ms = out_time_reg;
    assign speed_milli     = out_speed_reg;

    always_comb
    begin
        case (paddr[PADDR_W-1])
            wlpc_pkg::REG_LIGHT: prdata = PDATA_W'(light_reg);
            wlpc_pkg::REG_HEAVY: prdata = PDATA_W'(heavy_reg);
            default:             prdata = '0;
        endcase
    end

    assign mem_re = in_accept;
    assign mem_we = (state_reg == wlpc_pkg::S_READ);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[slot_reg] <= {lag_in_reg, skip_in_reg, wait_in_reg};
        end
        if (mem_re)
        begin
            rd_data_reg <= ring_mem[slot_reg];
        end
    end

    assign full     = (fill_reg == FILL_W'(WINDOW));
    assign old_lag  = rd_data_reg[ENTRY_W-1 -: LAG_W];
    assign old_skip = rd_data_reg[WAIT_W];
    assign old_wait = rd_data_reg[WAIT_W-1:0];

    assign l10        = (L10_W'(lag_sum_reg) << 3) + (L10_W'(lag_sum_reg) << 1);
    assign n12        = L10_W'(fill_reg) * L10_W'(12);
    assign n100       = L10_W'(fill_reg) * L10_W'(100);
    assign t_val      = l10 - n12;
    assign skip5      = SKIP5_W'(skip_sum_reg) * SKIP5_W'(5);
    assign low_lag    = (l10 < n12);
    assign heavy_case = (l10 >= n100);
    assign pos_wait   = (wait_sum_reg > 0);
    assign many_skips = (skip5 > SKIP5_W'(fill_reg));

    assign diff     = $signed({1'b0, heavy_reg}) - $signed({1'b0, light_reg});
    assign diff_ext = {{(PROD_W-DIFF_W){diff[DIFF_W-1]}}, diff};
    assign k_ext    = $signed(PROD_W'(k_reg));
    assign num_sum  = $signed(PROD_W'(prod_a_reg)) + prod_b_reg;

    assign rem_ge    = (rem_reg >= den_reg);
    assign rem_sub   = rem_ge ? (rem_reg - den_reg) : rem_reg;
    assign quo_shift = {quo_reg[SPEED_W-2:0], rem_ge};

    always_comb
    begin
        state_next     = state_reg;
        lag_in_next    = lag_in_reg;
        skip_in_next   = skip_in_reg;
        wait_in_next   = wait_in_reg;
        fill_next      = fill_reg;
        slot_next      = slot_reg;
        lag_sum_next   = lag_sum_reg;
        skip_sum_next  = skip_sum_reg;
        wait_sum_next  = wait_sum_reg;
        light_next     = light_reg;
        heavy_next     = heavy_reg;
        d_next         = d_reg;
        k_next         = k_reg;
        prod_a_next    = prod_a_reg;
        prod_b_next    = prod_b_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        speed_next     = speed_reg;
        time_next      = time_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_time_next  = out_time_reg;
        out_speed_next = out_speed_reg;

        if (cfg_write)
        begin
            case (paddr[PADDR_W-1])
                wlpc_pkg::REG_LIGHT: light_next = pwdata[SPEED_W-1:0];
                wlpc_pkg::REG_HEAVY: heavy_next = pwdata[SPEED_W-1:0];
                default:             light_next = light_reg;
            endcase
        end

        case (state_reg)
            wlpc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    lag_in_next  = lag_count;
                    skip_in_next = skipped;
                    wait_in_next = wait_amount;
                    state_next   = wlpc_pkg::S_READ;
                end
            end
            wlpc_pkg::S_READ:
            begin
                if (full)
                begin
                    lag_sum_next  = lag_sum_reg - LAG_SUM_W'(old_lag) + LAG_SUM_W'(lag_in_reg);
                    skip_sum_next = skip_sum_reg - SKIP_SUM_W'(old_skip)
                                  + SKIP_SUM_W'(skip_in_reg);
                    wait_sum_next = wait_sum_reg - WAIT_SUM_W'(old_wait)
                                  + WAIT_SUM_W'(wait_in_reg);
                end
                else
                begin
                    fill_next     = fill_reg + 1'b1;
                    lag_sum_next  = lag_sum_reg + LAG_SUM_W'(lag_in_reg);
                    skip_sum_next = skip_sum_reg + SKIP_SUM_W'(skip_in_reg);
                    wait_sum_next = wait_sum_reg + WAIT_SUM_W'(wait_in_reg);
                end
                slot_next  = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                state_next = wlpc_pkg::S_PREP;
            end
            wlpc_pkg::S_PREP:
            begin
                d_next = D_W'(fill_reg) * D_W'(88);
                k_next = heavy_case ? D_W'(D_W'(fill_reg) * D_W'(88)) : t_val[D_W-1:0];
                if (low_lag || pos_wait)
                begin
                    speed_next = many_skips ? wlpc_pkg::SPEED_SKIP : wlpc_pkg::SPEED_NORM;
                    time_next  = many_skips ? wlpc_pkg::TIME_SKIP : wlpc_pkg::TIME_NORM;
                    state_next = wlpc_pkg::S_OUT;
                end
                else
                begin
                    state_next = wlpc_pkg::S_PROD;
                end
            end
            wlpc_pkg::S_PROD:
            begin
                prod_a_next = NUM_W'(light_reg) * NUM_W'(d_reg);
                prod_b_next = diff_ext * k_ext;
                state_next  = wlpc_pkg::S_SUM;
            end
            wlpc_pkg::S_SUM:
            begin
                num_next   = num_sum[NUM_W-1:0];
                rem_next   = (DIVD_W'(num_sum[NUM_W-1:0]) << 1) + DIVD_W'(d_reg);
                den_next   = DIVD_W'(d_reg) << SPEED_W;
                quo_next   = '0;
                cnt_next   = CNT_W'(SPEED_W - 1);
                phase_next = 1'b0;
                state_next = wlpc_pkg::S_DIV;
            end
            wlpc_pkg::S_DIV:
            begin
                rem_next = rem_sub;
                den_next = den_reg >> 1;
                quo_next = quo_shift;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    if (!phase_reg)
                    begin
                        speed_next = quo_shift;
                        rem_next   = (DIVD_W'(num_reg) << 1)
                                   + DIVD_W'(d_reg) * DIVD_W'(10);
                        den_next   = (DIVD_W'(d_reg) * DIVD_W'(20)) << (TIME_W - 1);
                        quo_next   = '0;
                        cnt_next   = CNT_W'(TIME_W - 1);
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        time_next  = quo_shift[TIME_W-1:0];
                        state_next = wlpc_pkg::S_OUT;
                    end
                end
            end
            wlpc_pkg::S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_time_next  = time_reg;
                    out_speed_next = speed_reg;
                    state_next     = wlpc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wlpc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wlpc_pkg::S_IDLE;
            fill_reg      <= '0;
            slot_reg      <= '0;
            lag_sum_reg   <= '0;
            skip_sum_reg  <= '0;
            wait_sum_reg  <= '0;
            light_reg     <= wlpc_pkg::LIGHT_RESET;
            heavy_reg     <= wlpc_pkg::HEAVY_RESET;
            phase_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            slot_reg      <= slot_next;
            lag_sum_reg   <= lag_sum_next;
            skip_sum_reg  <= skip_sum_next;
            wait_sum_reg  <= wait_sum_next;
            light_reg     <= light_next;
            heavy_reg     <= heavy_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lag_in_reg    <= lag_in_next;
        skip_in_reg   <= skip_in_next;
        wait_in_reg   <= wait_in_next;
        d_reg         <= d_next;
        k_reg         <= k_next;
        prod_a_reg    <= prod_a_next;
        prod_b_reg    <= prod_b_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        quo_reg       <= quo_next;
        speed_reg     <= speed_next;
        time_reg      <= time_next;
        out_time_reg  <= out_time_next;
        out_speed_reg <= out_speed_next;
    end

    // one beat in flight at a time
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("input taken while a beat is in flight");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW))
        else $error("fill count beyond window");

    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wlpc_pkg::S_PROD) |-> (k_reg <= d_reg))
        else $error("lag offset beyond span");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wlpc_pkg::S_READ) |=> (fill_reg != '0))
        else $error("window empty after a beat was stored");

endmodule

`default_nettype wire

@@ tb/windowed_lag_pacing_controller_unit_test.sv @@
`default_nettype none

module windowed_lag_pacing_controller_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wlpc_pkg::*;

    typedef struct {
        logic [TIME_W-1:0]  time_ms;
        logic [SPEED_W-1:0] speed;
    } pace_t;

    class pace_scoreboard;
        logic [LAG_W-1:0] ring_lag [WINDOW];
        bit               ring_skip [WINDOW];
        int               ring_wait [WINDOW];
        int               fill;
        int               slot;
        int               lag_sum;
        int               skip_sum;
        int               wait_sum;
        int               light_speed;
        int               heavy_speed;
        int               fails;
        pace_t            expected_paces [$];

        function new();
            light_speed = int'(LIGHT_RESET);
            heavy_speed = int'(HEAVY_RESET);
        endfunction

        function void set_speed(logic idx, int value);
            if (idx == REG_LIGHT)
                light_speed = value & 'h7FF;
            else
                heavy_speed = value & 'h7FF;
        endfunction

        function int pending();
            return expected_paces.size();
        endfunction

        function void note_quantum(logic [LAG_W-1:0] lag, logic skp,
                                   logic signed [WAIT_W-1:0] w);
            longint n;
            longint d;
            longint k;
            longint num;
            pace_t  p;
            if (fill >= WINDOW) begin
                lag_sum  -= ring_lag[slot];
                skip_sum -= ring_skip[slot];
                wait_sum -= ring_wait[slot];
            end
            else begin
                fill++;
            end
            ring_lag[slot]  = lag;
            ring_skip[slot] = skp;
            ring_wait[slot] = int'(w);
            lag_sum  += lag;
            skip_sum += skp;
            wait_sum += int'(w);
            slot = (slot + 1) % WINDOW;

            n = fill;
            if (longint'(lag_sum) * 10 < 12 * n || wait_sum > 0) begin
                if (longint'(skip_sum) * 5 > n) begin
                    p.speed   = SPEED_SKIP;
                    p.time_ms = TIME_SKIP;
                end
                else begin
                    p.speed   = SPEED_NORM;
                    p.time_ms = TIME_NORM;
                end
            end
            else if (longint'(lag_sum) * 10 >= 100 * n) begin
                p.speed   = SPEED_W'(heavy_speed);
                p.time_ms = TIME_W'((heavy_speed + 5) / 10);
            end
            else begin
                // linear map over mean lag 1.2 .. 10.0, exact rational
                d   = 88 * n;
                k   = longint'(lag_sum) * 10 - 12 * n;
                num = longint'(light_speed) * d
                    + (longint'(heavy_speed) - longint'(light_speed)) * k;
                if (num < 0)
                    num = 0;
                p.speed   = SPEED_W'((2 * num + d) / (2 * d));
                p.time_ms = TIME_W'((2 * num + 10 * d) / (20 * d));
            end
            expected_paces.push_back(p);
        endfunction

        function void check_pace(logic [TIME_W-1:0] t, logic [SPEED_W-1:0] s);
            pace_t p;
            if (expected_paces.size() == 0) begin
                $display("%0t: result beat with none pending: quantum_time_ms %0d speed_milli %0d",
                         $time, t, s);
                fails++;
                return;
            end
            p = expected_paces.pop_front();
            if (t !== p.time_ms) begin
                $display("%0t: quantum_time_ms expected %0d actual %0d", $time, p.time_ms, t);
                fails++;
            end
            if (s !== p.speed) begin
                $display("%0t: speed_milli expected %0d actual %0d", $time, p.speed, s);
                fails++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [LAG_W-1:0]          lag_count;
    logic                      skipped;
    logic signed [WAIT_W-1:0]  wait_amount;
    logic                      out_valid;
    logic                      out_stall;
    logic [TIME_W-1:0]         quantum_time_ms;
    logic [SPEED_W-1:0]        speed_milli;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [PADDR_W-1:0]        paddr;
    logic [PDATA_W-1:0]        pwdata;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    pace_scoreboard pacing;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             hold_off_cycles;

    windowed_lag_pacing_controller_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .lag_count       (lag_count),
        .skipped         (skipped),
        .wait_amount     (wait_amount),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .quantum_time_ms (quantum_time_ms),
        .speed_milli     (speed_milli),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL windowed_lag_pacing_controller_unit");
        $finish;
    end

    // receiver: random stall, or a long hold-off when requested
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0) begin
                out_stall = 1'b1;
                hold_off_cycles--;
            end
            else begin
                out_stall = ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                pacing.note_quantum(lag_count, skipped, wait_amount);
            if (out_valid && !out_stall)
                pacing.check_pace(quantum_time_ms, speed_milli);
        end
    end

    task automatic send_beat(logic [LAG_W-1:0] lag, logic skp, logic [WAIT_W-1:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        lag_count   = lag;
        skipped     = skp;
        wait_amount = w;
        in_valid    = 1'b1;
        do @(posedge clk); while (!(in_valid && !in_stall));
        @(negedge clk);
    endtask

    task automatic write_reg(logic idx, int value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'(idx) << 2;
        pwdata  = PDATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        pacing.set_speed(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (pacing.pending() != 0)
            @(posedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic send_random(int lag_ceil, int wait_mode, int skip_pct);
        logic [LAG_W-1:0]  lag;
        logic [WAIT_W-1:0] w;
        lag = LAG_W'($urandom_range(0, lag_ceil));
        if ($urandom_range(99) < 3)
            lag = '1;
        if (wait_mode == 1 || $urandom_range(99) < 10)
            w = WAIT_W'($urandom());
        else
            w = WAIT_W'(-$urandom_range(0, 300));
        send_beat(lag, $urandom_range(99) < skip_pct, w);
    endtask

    int dir_lag  [24] = '{0, 0, 255, 255, 0, 0, 0, 1, 2, 3, 4, 5,
                          6, 7, 8, 9, 10, 11, 12, 1, 1, 1, 128, 0};
    bit dir_skip [24] = '{0, 1, 0, 1, 0, 0, 0, 1, 0, 0, 1, 0,
                          0, 0, 1, 0, 0, 0, 0, 1, 1, 1, 0, 0};
    int dir_wait [24] = '{0, 0, -32768, 32767, 1, 1, -2, -1, 0, -5, 0, -100,
                          0, 0, 0, 0, 0, 0, -7, 0, 0, 32767, -32768, 0};
    int ph_light [6]  = '{2000, 0, 2000, 0, -1, 900};
    int ph_heavy [6]  = '{0, 2000, 2000, 0, -1, 500};
    int ph_send  [6]  = '{0, 45, 0, 21, 0, 45};
    int ph_recv  [6]  = '{0, 0, 45, 21, 0, 45};
    int lag_ceils [5] = '{2, 3, 8, 20, 255};

    initial
    begin
        int lag_ceil;
        int wait_mode;
        int skip_pct;
        int lv;
        int hv;
        pacing          = new();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        lag_count   = '0;
        skipped     = 1'b0;
        wait_amount = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < 24; i++)
            send_beat(LAG_W'(dir_lag[i]), dir_skip[i], WAIT_W'(dir_wait[i]));
        drain_results();

        for (int ph = 0; ph < 6; ph++) begin
            lv = (ph_light[ph] < 0) ? $urandom_range(0, 2000) : ph_light[ph];
            hv = (ph_heavy[ph] < 0) ? $urandom_range(0, 2000) : ph_heavy[ph];
            write_reg(REG_LIGHT, lv);
            write_reg(REG_HEAVY, hv);
            send_idle_pct  = ph_send[ph];
            recv_stall_pct = ph_recv[ph];
            if (ph == 4)
                hold_off_cycles = 400;
            for (int i = 0; i < 115; i++) begin
                if (i % 30 == 0) begin
                    lag_ceil  = lag_ceils[$urandom_range(0, 4)];
                    wait_mode = ($urandom_range(99) < 30);
                    skip_pct  = $urandom_range(0, 50);
                end
                // a stretch without idling inside the last idle phase
                if (ph == 5 && i == 60) begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                send_random(lag_ceil, wait_mode, skip_pct);
            end
            drain_results();
        end

        if (pacing.fails == 0)
            $display("PASS windowed_lag_pacing_controller_unit");
        else
            $display("FAIL windowed_lag_pacing_controller_unit");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/wlpc_pkg.sv
hdl/windowed_lag_pacing_controller_unit.sv
tb/windowed_lag_pacing_controller_unit_test.sv
